@@ hdl/skvt_pkg.sv @@
`default_nettype none

package skvt_pkg;

  // Default table size, in entries.
  localparam int CAPACITY_DEF = 128;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_INSERT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] key;
    logic [31:0]        value_cents;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_value;
    logic [7:0]  entry_count;
  } rsp_t;

  // One table row as it sits in the memory.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
  } entry_t;

endpackage

`default_nettype wire

@@ hdl/sorted_key_value_table.sv @@
// Sorted key/value table. Holds up to CAPACITY unique signed 32-bit keys,
// each with an unsigned price in cents, in ascending key order. Each request
// is an insert, a remove, a search or a nop, and each request answers with
// exactly one response carrying a status, the price found by a search, and
// the entry count after the request. A request runs alone: req_ready is high
// only while the sequencer is idle. A search scans from the front until it
// stops at its row; an insert scans to its insertion point, shifts every
// later entry up a row and writes the new entry; a remove scans to its row
// and shifts every later entry down a row. The table memory reads one row
// and writes one row per cycle: the scan compares one stored key per cycle,
// and every entry that moves takes one memory write. A nop code, an insert
// into a full table, or a remove or search on an empty table answers without
// a scan. The memory needs no clearing after reset, because data read from a
// row at or above the entry count is never used. A finished response waits
// in an output register, so a new request is taken while the previous
// response is still pending.

`default_nettype none

module sorted_key_value_table #(
  parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire skvt_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output skvt_pkg::rsp_t      rsp
);
  import skvt_pkg::*;

  localparam int IW = $clog2(CAPACITY);

  logic          out_free;
  logic          res_load;
  rsp_t          res;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_rdata;

  // The sequencer may hand over a response when the output register is empty
  // or is being emptied in this same cycle.
  assign out_free = !rsp_valid || rsp_ready;

  skvt_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req      (req),
    .idle     (req_ready),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  // The table rows, kept sorted by key.
  skvt_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Output register: the valid flag is reset, the payload is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

@@ hdl/skvt_mem.sv @@
`default_nettype none

module skvt_mem #(
  parameter int DEPTH = skvt_pkg::CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire skvt_pkg::entry_t         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output skvt_pkg::entry_t              rdata
);
  import skvt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/skvt_ctrl.sv @@
`default_nettype none

module skvt_ctrl #(
  parameter int CAPACITY = skvt_pkg::CAPACITY_DEF,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  wire skvt_pkg::req_t   req,
  output logic                  idle,
  input  wire logic             out_free,
  output logic                  res_load,
  output skvt_pkg::rsp_t        res,
  output logic                  mem_we,
  output logic [IW-1:0]         mem_waddr,
  output skvt_pkg::entry_t      mem_wdata,
  output logic [IW-1:0]         mem_raddr,
  input  wire skvt_pkg::entry_t mem_rdata
);
  import skvt_pkg::*;

  state_e      state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] count, count_next;
  status_e     status_q, status_next;
  logic [31:0] found_q, found_next;
  logic [1:0]  cmd_q;
  logic [31:0] key_q;
  logic [31:0] value_q;
  logic        at_end;
  logic        less;
  logic        hit;

  assign idle = (state == S_IDLE);

  // The shared comparator: one stored key against the command key per cycle.
  assign at_end = (idx == count);
  assign less   = !at_end && ($signed(mem_rdata.key) < $signed(key_q));
  assign hit    = !at_end && (mem_rdata.key == key_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    pos      <= pos_next;
    status_q <= status_next;
    found_q  <= found_next;
    if (state == S_IDLE && req_valid) begin
      cmd_q   <= req.cmd;
      key_q   <= req.key;
      value_q <= req.value_cents;
    end
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    pos_next    = pos;
    count_next  = count;
    status_next = status_q;
    found_next  = found_q;
    mem_we      = 1'b0;
    mem_waddr   = idx[IW-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = '0;
    res_load    = 1'b0;

    case (state)
      S_IDLE: begin
        idx_next    = '0;
        found_next  = '0;
        status_next = ST_OK;
        if (req_valid) begin
          if (req.cmd == CMD_NOP) begin
            state_next = S_DONE;
          end else if (req.cmd == CMD_INSERT && count == CW'(CAPACITY)) begin
            status_next = ST_FULL;
            state_next  = S_DONE;
          end else if (req.cmd != CMD_INSERT && count == '0) begin
            status_next = ST_EMPTY;
            state_next  = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Prefetch the next row so that the scan runs one row per cycle.
        mem_raddr = IW'(idx + CW'(1));
        if (less) begin
          idx_next = idx + CW'(1);
        end else begin
          case (cmd_q)
            CMD_INSERT: begin
              pos_next = idx;
              if (hit) begin
                status_next = ST_DUP;
                state_next  = S_DONE;
              end else if (at_end) begin
                state_next = S_INSERT;
              end else begin
                idx_next   = count;
                mem_raddr  = IW'(count - CW'(1));
                state_next = S_SHIFT_UP;
              end
            end
            CMD_SEARCH: begin
              if (hit) begin
                found_next = mem_rdata.value;
              end else begin
                status_next = ST_NOT_FOUND;
              end
              state_next = S_DONE;
            end
            CMD_REMOVE: begin
              if (!hit) begin
                status_next = ST_NOT_FOUND;
                state_next  = S_DONE;
              end else if (idx + CW'(1) == count) begin
                count_next = count - CW'(1);
                state_next = S_DONE;
              end else begin
                state_next = S_SHIFT_DN;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_raddr = IW'(idx - CW'(2));
        if (idx == pos + CW'(1)) begin
          state_next = S_INSERT;
        end else begin
          idx_next = idx - CW'(1);
        end
      end

      S_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_raddr = IW'(idx + CW'(2));
        if (idx + CW'(2) == count) begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end else begin
          idx_next = idx + CW'(1);
        end
      end

      S_INSERT: begin
        mem_we     = 1'b1;
        mem_waddr  = pos[IW-1:0];
        mem_wdata  = '{key: key_q, value: value_q};
        count_next = count + CW'(1);
        state_next = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res = '{status: status_q, found_value: found_q, entry_count: 8'(count)};

endmodule

`default_nettype wire

@@ hdl/skvt_chk.sv @@
`default_nettype none

module skvt_chk #(
  parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire skvt_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire skvt_pkg::rsp_t rsp
);
  import skvt_pkg::*;

  localparam logic [7:0] CAP_LOW = 8'(CAPACITY);

  // A waiting request keeps its contents until it is taken.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while waiting");

  // A stalled response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Only a successful search reports a price.
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.found_value == 32'd0)
    else $error("price reported on a failed request");

  // A full refusal leaves the table at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == CAP_LOW)
    else $error("table full reported below capacity");

  // An empty refusal leaves the table empty.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EMPTY |-> rsp.entry_count == 8'd0)
    else $error("table empty reported with entries held");

endmodule

bind sorted_key_value_table skvt_chk #(.CAPACITY(CAPACITY)) u_skvt_chk (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import skvt_pkg::*;

  // Random requests after the directed opening.
  localparam int RANDOM_REQUESTS = 1300;
  // Requests per traffic phase; the phases rotate fill, mixed, drain.
  localparam int PHASE_LEN = 200;
  // Response hold-off used once to back the table up.
  localparam int HOLD_CYCLES = 400;
  // Hard stop, far above the slowest legal run.
  localparam int LIMIT_CYCLES = 1000000;

  // The scoreboard keeps its own copy of the sorted table. Every accepted
  // request is applied to that copy at once, which gives the response the
  // block owes for it; responses are then matched in order.
  class skvt_scoreboard;
    logic signed [31:0] keys[$];
    logic [31:0]        prices[$];
    rsp_t               expected_q[$];
    int                 errors;
    int                 checked;
    int                 requests;
    int                 status_hits[8];

    function void note_request(req_t r);
      rsp_t want;
      int   pos;
      bit   hit;
      want = '0;
      pos  = 0;
      // Insertion point: first row whose key is not below the request key.
      while (pos < keys.size() && keys[pos] < r.key) pos++;
      hit = (pos < keys.size()) && (keys[pos] == r.key);
      want.status = ST_OK;
      case (cmd_e'(r.cmd))
        CMD_INSERT: begin
          // A full table refuses before the duplicate test is made.
          if (keys.size() >= CAPACITY_DEF) begin
            want.status = ST_FULL;
          end else if (hit) begin
            want.status = ST_DUP;
          end else begin
            keys.insert(pos, r.key);
            prices.insert(pos, r.value_cents);
          end
        end
        CMD_REMOVE, CMD_SEARCH: begin
          if (keys.size() == 0) begin
            want.status = ST_EMPTY;
          end else if (!hit) begin
            want.status = ST_NOT_FOUND;
          end else if (cmd_e'(r.cmd) == CMD_SEARCH) begin
            want.found_value = prices[pos];
          end else begin
            keys.delete(pos);
            prices.delete(pos);
          end
        end
        default: begin
          // The spare code leaves the table alone and answers OK.
        end
      endcase
      want.entry_count = 8'(keys.size());
      expected_q.push_back(want);
      requests++;
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: response with nothing outstanding, expected none, actual %0h",
                 $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      status_hits[want.status]++;
      if (got.status !== want.status) report("status", 32'(want.status), 32'(got.status));
      if (got.found_value !== want.found_value)
        report("found_value", want.found_value, got.found_value);
      if (got.entry_count !== want.entry_count)
        report("entry_count", 32'(want.entry_count), 32'(got.entry_count));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int live_count();
      return keys.size();
    endfunction

    // A key that is currently stored, so that removes and searches hit.
    function logic signed [31:0] live_key();
      return keys[$urandom_range(0, keys.size() - 1)];
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  skvt_scoreboard sb;
  int  cycles;
  // While calm is set neither side idles; hold_request asks the response
  // side for its one long stall.
  bit  calm;
  bit  hold_request;
  bit  hold_done;

  sorted_key_value_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Runaway guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d responses outstanding",
               cycles, sb.pending());
      $display("FAIL sorted_key_value_table");
      $finish;
    end
  end

  // Responses are sampled on the rising edge, with the values the block
  // drove before that edge.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  // Response side. It stalls at random about a quarter of the time, never in the
  // calm window, and once holds off for a long stretch so that a finished
  // response sits in the output register and the request side backs up.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        rsp_ready <= calm || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  function automatic req_t mk(cmd_e c, logic signed [31:0] k, logic [31:0] v);
    req_t r;
    r.cmd         = c;
    r.key         = k;
    r.value_cents = v;
    return r;
  endfunction

  // Keys come in three flavors: the two's complement corners, anything at
  // all, and a narrow band around zero where neighbors collide often.
  function automatic logic signed [31:0] rand_key();
    int band;
    band = $urandom_range(0, 511);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3, 4: return $urandom;
      default:    return band - 256;
    endcase
  endfunction

  // Random traffic shaped by phase. Fill phases are insert heavy and run
  // the table up to full; drain phases remove stored keys until it is
  // empty and keep poking it there; mixed phases churn in between.
  function automatic req_t make_request(int idx);
    int                 phase;
    int                 roll;
    int                 ins_pct;
    int                 rem_pct;
    int                 srch_pct;
    int                 live_pct;
    cmd_e               c;
    logic signed [31:0] k;
    phase = (idx / PHASE_LEN) % 3;
    roll  = $urandom_range(0, 99);
    case (phase)
      0: begin ins_pct = 88; rem_pct = 5;  srch_pct = 5;  live_pct = 75; end
      1: begin ins_pct = 38; rem_pct = 30; srch_pct = 28; live_pct = 75; end
      default: begin ins_pct = 6; rem_pct = 82; srch_pct = 10; live_pct = 92; end
    endcase
    if (roll < ins_pct)                           c = CMD_INSERT;
    else if (roll < ins_pct + rem_pct)            c = CMD_REMOVE;
    else if (roll < ins_pct + rem_pct + srch_pct) c = CMD_SEARCH;
    else                                          c = CMD_NOP;
    k = rand_key();
    if (sb.live_count() > 0) begin
      // Inserts sometimes repeat a stored key; removes and searches mostly
      // aim at one.
      if (c == CMD_INSERT && $urandom_range(0, 99) < 10) k = sb.live_key();
      else if (c != CMD_INSERT && $urandom_range(0, 99) < live_pct) k = sb.live_key();
    end
    return mk(c, k, $urandom);
  endfunction

  // Offers one request, idling first at random, and returns on the falling
  // edge after it was accepted. Valid stays high until the handshake.
  task automatic send_request(input req_t r);
    while (!calm && $urandom_range(0, 99) < 24) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  initial begin
    sb        = new();
    cycles    = 0;
    calm      = 1'b0;
    hold_request = 1'b0;
    hold_done = 1'b0;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening. Searches and removes on an empty table come first,
    // then the key and price corners, a duplicate, hits and misses, the
    // spare code, and removes at the middle, front and back of the table
    // until it is empty again. Full-table inserts come from the fill phases.
    send_request(mk(CMD_SEARCH, 32'sd0, 32'h0));
    send_request(mk(CMD_REMOVE, 32'sd5, 32'hFFFF_FFFF));
    send_request(mk(CMD_INSERT, 32'sd0, 32'h0));
    send_request(mk(CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_request(mk(CMD_INSERT, 32'h8000_0000, 32'h1234_5678));
    send_request(mk(CMD_INSERT, -32'sd1, 32'h8000_0000));
    send_request(mk(CMD_INSERT, 32'sd1, 32'h0000_0001));
    send_request(mk(CMD_INSERT, 32'sd0, 32'hAAAA_5555));
    send_request(mk(CMD_SEARCH, 32'h8000_0000, 32'h0));
    send_request(mk(CMD_SEARCH, 32'h7FFF_FFFF, 32'h0));
    send_request(mk(CMD_SEARCH, -32'sd1, 32'h0));
    send_request(mk(CMD_SEARCH, 32'sd2, 32'h0));
    send_request(mk(CMD_REMOVE, 32'sd2, 32'h0));
    send_request(mk(CMD_NOP, -32'sd1, 32'h5555_AAAA));
    send_request(mk(CMD_REMOVE, 32'sd0, 32'h0));
    send_request(mk(CMD_REMOVE, 32'h8000_0000, 32'h0));
    send_request(mk(CMD_REMOVE, 32'h7FFF_FFFF, 32'h0));
    send_request(mk(CMD_SEARCH, 32'sd0, 32'h0));
    send_request(mk(CMD_INSERT, -32'sd2, 32'h0000_FFFF));
    send_request(mk(CMD_SEARCH, -32'sd2, 32'h0));
    send_request(mk(CMD_REMOVE, -32'sd1, 32'h0));
    send_request(mk(CMD_REMOVE, 32'sd1, 32'h0));
    send_request(mk(CMD_REMOVE, -32'sd2, 32'h0));
    send_request(mk(CMD_SEARCH, 32'sd1, 32'h0));

    // Random part. One window runs with no idling on either side, and at
    // request 900, well after that window, the response side takes its long hold-off.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      calm = (i >= 400 && i < 600);
      if (i == 900) hold_request = 1'b1;
      send_request(make_request(i));
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    // Drain, then leave a full worst-case operation's worth of cycles for
    // any stray response to show up.
    while (sb.pending() != 0) @(posedge clk);
    repeat (CAPACITY_DEF + 20) @(posedge clk);

    $display("%0d requests, %0d responses checked in %0d cycles, %0d errors",
             sb.requests, sb.checked, cycles, sb.errors);
    $display("statuses ok %0d, duplicate %0d, full %0d, not found %0d, empty %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_DUP], sb.status_hits[ST_FULL],
             sb.status_hits[ST_NOT_FOUND], sb.status_hits[ST_EMPTY]);
    if (sb.errors == 0) begin
      $display("PASS sorted_key_value_table");
    end else begin
      $display("FAIL sorted_key_value_table");
    end
    $finish;
  end

endmodule
